// File: hw/rtl/sird_pkg.sv
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types, constants and helpers for the signed integer to radix digits
// block.
// ----------------------------------------------------------------------------
package sird_pkg;

   localparam int MAG_W   = 32;
   localparam int DIGIT_W = 4;
   localparam int NUM_CH  = 16;
   localparam int CNT_W   = 6;

   localparam logic [1:0] CSR_BASE_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_DIGITS_LOWER = 2'd1;
   localparam logic [1:0] CSR_DIGITS_UPPER = 2'd2;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HIGH  = 8'h80;

   typedef struct packed {
      logic [4:0]   base_length;
      logic [127:0] digits;
   } cfg_type;

   typedef struct packed {
      logic              negative;
      logic [MAG_W-1:0]  magnitude;
   } entry_type;

   function automatic logic [7:0] digit_char(input logic [127:0] digits,
                                             input logic [DIGIT_W-1:0] idx);
      digit_char = digits[{idx, 3'b000} +: 8];
   endfunction

endpackage

// File: hw/rtl/sird_ifs.sv
// ----------------------------------------------------------------------------
// sird channel interfaces
// Valid/ready channels for input values, output characters and csr writes.
// ----------------------------------------------------------------------------
interface sird_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sird_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       is_last;
   modport source (output valid, output character, output is_last, input ready);
   modport sink   (input valid, input character, input is_last, output ready);
endinterface

interface sird_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/sird_fifo.sv
// ----------------------------------------------------------------------------
// sird_fifo
// Two-entry queue of classified values between front and back.
// ----------------------------------------------------------------------------
module sird_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sird_pkg::entry_type push_data,
   input  logic                pop,
   output sird_pkg::entry_type pop_data,
   output logic                full,
   output logic                empty
);

   sird_pkg::entry_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/sird_front.sv
// ----------------------------------------------------------------------------
// sird_front
// Accepts input values, checks the alphabet, queues sign and magnitude if valid.
// ----------------------------------------------------------------------------
module sird_front #(
   parameter int MAX_RADIX = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  sird_pkg::cfg_type   cfg,
   sird_req_if.sink            req_if,
   input  logic                fifo_full,
   output logic                fifo_push,
   output sird_pkg::entry_type fifo_data
);

   localparam logic [4:0] MAX_N = 5'(MAX_RADIX);

   logic               occ_ff, occ_in;
   logic signed [31:0] value_ff, value_in;
   logic               alph_ok_ff, alph_ok_in;

   function automatic logic alphabet_ok(input sird_pkg::cfg_type c);
      logic       ok;
      logic [7:0] ch;
      ok = (c.base_length >= 5'd2) && (c.base_length <= MAX_N) &&
           (c.base_length <= 5'(sird_pkg::NUM_CH));
      for (int i = 0; i < sird_pkg::NUM_CH; i++) begin
         ch = sird_pkg::digit_char(c.digits, 4'(i));
         if (5'(i) < c.base_length) begin
            if (ch == sird_pkg::CHAR_PLUS || ch == sird_pkg::CHAR_MINUS ||
                ch <= sird_pkg::CHAR_SPACE || ch >= sird_pkg::CHAR_HIGH) begin
               ok = 1'b0;
            end
            for (int j = i + 1; j < sird_pkg::NUM_CH; j++) begin
               if (5'(j) < c.base_length &&
                   sird_pkg::digit_char(c.digits, 4'(j)) == ch) begin
                  ok = 1'b0;
               end
            end
         end
      end
      return ok;
   endfunction

   assign req_if.ready = !occ_ff;
   assign alph_ok_in   = alphabet_ok(cfg);

   always_comb begin
      occ_in    = occ_ff;
      value_in  = value_ff;
      fifo_push = 1'b0;
      fifo_data.negative  = value_ff[31];
      fifo_data.magnitude = value_ff[31] ? (32'd0 - value_ff) : value_ff;
      if (occ_ff) begin
         if (!alph_ok_ff) begin
            occ_in = 1'b0;
         end else if (!fifo_full) begin
            fifo_push = 1'b1;
            occ_in    = 1'b0;
         end
      end
      if (req_if.valid && req_if.ready) begin
         occ_in   = 1'b1;
         value_in = req_if.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= 1'b0;
         alph_ok_ff <= 1'b0;
      end else begin
         occ_ff     <= occ_in;
         alph_ok_ff <= alph_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// File: hw/rtl/sird_back.sv
// ----------------------------------------------------------------------------
// sird_back
// Divides the magnitude by the radix, eight quotient bits a cycle, buffers
// the digits and emits sign and digits most significant first.
// ----------------------------------------------------------------------------
module sird_back (
   input  logic                clock,
   input  logic                reset,
   input  sird_pkg::cfg_type   cfg,
   input  logic                fifo_empty,
   input  sird_pkg::entry_type fifo_data,
   output logic                fifo_pop,
   sird_rsp_if.source          rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;
   localparam int STEPS = 8;

   logic [1:0]                       state_ff, state_in;
   logic [1:0]                       step_ff, step_in;
   logic [sird_pkg::CNT_W-1:0]       nd_ff, nd_in;
   logic                             neg_ff, neg_in;
   logic [sird_pkg::MAG_W-1:0]       quot_ff, quot_in;
   logic [sird_pkg::DIGIT_W-1:0]     rem_ff, rem_in;
   logic [sird_pkg::DIGIT_W-1:0]     buf_ff [sird_pkg::MAG_W];
   logic                             buf_we;
   logic [sird_pkg::MAG_W-1:0]       q_next;
   logic [sird_pkg::DIGIT_W-1:0]     r_next;
   logic [sird_pkg::DIGIT_W:0]       t;
   logic [sird_pkg::CNT_W-1:0]       rd_pos;
   logic [7:0]                       out_char;

   // eight restoring division steps per cycle
   always_comb begin
      q_next = quot_ff;
      r_next = rem_ff;
      t      = '0;
      for (int k = 0; k < STEPS; k++) begin
         t      = {r_next, q_next[sird_pkg::MAG_W-1]};
         q_next = {q_next[sird_pkg::MAG_W-2:0], 1'b0};
         if (t >= cfg.base_length) begin
            t         = t - cfg.base_length;
            q_next[0] = 1'b1;
         end
         r_next = t[sird_pkg::DIGIT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      nd_in    = nd_ff;
      neg_in   = neg_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      fifo_pop = 1'b0;
      buf_we   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               neg_in   = fifo_data.negative;
               quot_in  = fifo_data.magnitude;
               rem_in   = '0;
               step_in  = '0;
               nd_in    = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = q_next;
            rem_in  = r_next;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               buf_we = 1'b1;
               nd_in  = nd_ff + 6'd1;
               rem_in = '0;
               if (q_next == '0 || nd_ff >= 6'd31) begin
                  state_in = neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
         end
         ST_SIGN: begin
            if (rsp_if.ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_if.ready) begin
               nd_in = nd_ff - 6'd1;
               if (nd_ff == 6'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_pos   = nd_ff - 6'd1;
   assign out_char = sird_pkg::digit_char(cfg.digits, buf_ff[rd_pos[4:0]]);

   assign rsp_if.valid     = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_if.character = (state_ff == ST_SIGN) ? sird_pkg::CHAR_MINUS[6:0]
                                                   : out_char[6:0];
   assign rsp_if.is_last   = (state_ff == ST_EMIT) && (nd_ff == 6'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         nd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         nd_ff    <= nd_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (buf_we) begin
         buf_ff[nd_ff[4:0]] <= r_next;
      end
   end

endmodule

// File: hw/rtl/signed_int_to_radix_digits_top.sv
// flow: the front registers each input beat and, with a valid alphabet, queues it
//   for the divider, which works digit by digit; then one output beat per cycle,
//   while the output is ready, for the sign and each digit. A new value can queue
//   as one converts; the single digit divider limits how fast values get through
// reset: synchronous, clears the registers to 0, the queue and all control
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits_top
// Converts signed 32-bit values to text in a radix set by a csr alphabet.
// ----------------------------------------------------------------------------
module signed_int_to_radix_digits_top #(
   parameter int MAX_RADIX = 16
) (
   input  logic       clock,
   input  logic       reset,
   sird_req_if.sink   req_if,
   sird_rsp_if.source rsp_if,
   sird_csr_if.sink   csr_if
);

   logic [4:0]          base_length_ff, base_length_in;
   logic [63:0]         digits_lower_ff, digits_lower_in;
   logic [63:0]         digits_upper_ff, digits_upper_in;
   sird_pkg::cfg_type   cfg;
   sird_pkg::entry_type push_data;
   sird_pkg::entry_type pop_data;
   logic                fifo_push, fifo_pop, fifo_full, fifo_empty;

   assign csr_if.ready = 1'b1;
   assign cfg          = {base_length_ff, digits_upper_ff, digits_lower_ff};

   always_comb begin
      base_length_in  = base_length_ff;
      digits_lower_in = digits_lower_ff;
      digits_upper_in = digits_upper_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            sird_pkg::CSR_BASE_LENGTH:  base_length_in  = csr_if.data[4:0];
            sird_pkg::CSR_DIGITS_LOWER: digits_lower_in = csr_if.data;
            sird_pkg::CSR_DIGITS_UPPER: digits_upper_in = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff  <= '0;
         digits_lower_ff <= '0;
         digits_upper_ff <= '0;
      end else begin
         base_length_ff  <= base_length_in;
         digits_lower_ff <= digits_lower_in;
         digits_upper_ff <= digits_upper_in;
      end
   end

   sird_front #(
      .MAX_RADIX (MAX_RADIX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_if    (req_if),
      .fifo_full (fifo_full),
      .fifo_push (fifo_push),
      .fifo_data (push_data)
   );

   sird_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   sird_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .fifo_pop   (fifo_pop),
      .rsp_if     (rsp_if)
   );

   // output is quiet right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("rsp beat right after reset");

   // a finished number leaves a gap before the next one
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.is_last) |=> !rsp_if.valid)
      else $error("rsp beat directly after last character");

   // front holds one value at a time
   a_front_single: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("front accepted while occupied");

   // the queue is never pushed beyond its depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !fifo_push)
      else $error("queue overflow");

endmodule

// File: test/sird_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sird_text_checker
// Passive checker for the signed integer to radix digits block. It tracks the
// alphabet registers from csr beats, spells every accepted value while
// that alphabet is valid and compares each beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module sird_text_checker #(
   parameter int MAX_RADIX = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [6:0]         rsp_character,
   input  logic               rsp_is_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_data,
   output int                 mismatches,
   output int                 pending
);

   typedef struct packed {
      logic [6:0] character;
      logic       is_last;
   } text_beat_type;

   logic [4:0]    radix_len;
   logic [127:0]  glyphs;
   text_beat_type due_text[$];
   text_beat_type got;
   int            fails;

   function automatic bit alphabet_ok(input logic [4:0] len, input logic [127:0] set);
      int         n;
      logic [7:0] c;
      n = len;
      if (n < 2 || n > MAX_RADIX || n > 16) return 1'b0;
      for (int i = 0; i < n; i++) begin
         c = set[8*i +: 8];
         if (c == sird_pkg::CHAR_PLUS || c == sird_pkg::CHAR_MINUS ||
             c <= sird_pkg::CHAR_SPACE || c >= sird_pkg::CHAR_HIGH)
            return 1'b0;
         for (int j = i + 1; j < n; j++) begin
            if (set[8*j +: 8] == c) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic void spell_value(input logic signed [31:0] value);
      logic [31:0]   mag;
      logic [31:0]   radix;
      int            digit_buf[32];
      int            nd;
      text_beat_type beat;
      if (!alphabet_ok(radix_len, glyphs)) return;
      radix = {27'd0, radix_len};
      mag = value;
      if (value[31]) mag = ~mag + 32'd1;
      nd = 0;
      do begin
         digit_buf[nd] = int'(mag % radix);
         mag = mag / radix;
         nd++;
      end while (mag != 32'd0 && nd < 32);
      if (value[31]) begin
         beat.character = sird_pkg::CHAR_MINUS[6:0];
         beat.is_last = 1'b0;
         due_text.push_back(beat);
      end
      while (nd > 0) begin
         nd--;
         beat.character = glyphs[8*digit_buf[nd] +: 7];
         beat.is_last = (nd == 0);
         due_text.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         radix_len = '0;
         glyphs = '0;
         due_text.delete();
         fails = 0;
         mismatches <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_text.size() == 0) begin
               $error("character beat %02h with nothing expected", rsp_character);
               fails++;
            end else begin
               got = due_text.pop_front();
               if (got.character !== rsp_character) begin
                  $error("character: expected %02h, actual %02h", got.character, rsp_character);
                  fails++;
               end
               if (got.is_last !== rsp_is_last) begin
                  $error("is_last: expected %0b, actual %0b", got.is_last, rsp_is_last);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sird_pkg::CSR_BASE_LENGTH:  radix_len = csr_data[4:0];
               sird_pkg::CSR_DIGITS_LOWER: glyphs[63:0] = csr_data;
               sird_pkg::CSR_DIGITS_UPPER: glyphs[127:64] = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) spell_value(req_value);
         mismatches <= fails;
         pending <= due_text.size();
      end
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for signed_int_to_radix_digits_top. Loads valid and
// broken alphabets between phases, feeds directed and random values with
// random gaps and output stalls, and leaves the comparison to the checker.
// ----------------------------------------------------------------------------
module tb;

   typedef enum int {
      FLAW_PLUS,
      FLAW_MINUS,
      FLAW_NUL,
      FLAW_SPACE,
      FLAW_CONTROL,
      FLAW_HIGH,
      FLAW_REPEAT
   } flaw_kind_type;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int SPELLED_TARGET = 380;
   localparam int IDLE_LIMIT     = 20000;
   localparam int SETTLE_CYCLES  = 1500;
   localparam int HOLD_CYCLES    = 800;
   localparam int TAIL_CYCLES    = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   pending;
   int   hold_asks = 0;
   int   holds_done = 0;
   int   idle_cycles = 0;
   bit   steady = 1'b0;

   sird_req_if req_bus ();
   sird_rsp_if rsp_bus ();
   sird_csr_if csr_bus ();

   signed_int_to_radix_digits_top #(
      .MAX_RADIX(16)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   sird_text_checker #(
      .MAX_RADIX(16)
   ) text_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_value     (req_bus.value),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_character (rsp_bus.character),
      .rsp_is_last   (rsp_bus.is_last),
      .csr_valid     (csr_bus.valid),
      .csr_ready     (csr_bus.ready),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: v = 32'sd0;
               1: v = -32'sd1;
               2: v = 32'sh7FFF_FFFF;
               3: v = 32'sh8000_0000;
               default: v = 32'sd1;
            endcase
         end
         1, 2, 3: v = $urandom_range(0, 40) - 20;
         4, 5: begin
            v = $urandom_range(0, 65535);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [127:0] text_alphabet(input string s);
      logic [127:0] set;
      set = '0;
      for (int i = 0; i < s.len() && i < 16; i++) set[8*i +: 8] = s[i];
      return set;
   endfunction

   function automatic logic [127:0] make_alphabet(input int n);
      logic [127:0] set;
      bit           used[256];
      int           c;
      for (int i = 0; i < 16; i++) set[8*i +: 8] = 8'($urandom_range(0, 255));
      for (int i = 0; i < n; i++) begin
         do c = $urandom_range(33, 127);
         while (c == sird_pkg::CHAR_PLUS || c == sird_pkg::CHAR_MINUS || used[c]);
         used[c] = 1'b1;
         set[8*i +: 8] = 8'(c);
      end
      return set;
   endfunction

   function automatic logic [127:0] spoil_alphabet(input logic [127:0] set, input int n,
                                                   input flaw_kind_type flaw);
      int pos;
      int other;
      pos = $urandom_range(0, n - 1);
      case (flaw)
         FLAW_PLUS:    set[8*pos +: 8] = sird_pkg::CHAR_PLUS;
         FLAW_MINUS:   set[8*pos +: 8] = sird_pkg::CHAR_MINUS;
         FLAW_NUL:     set[8*pos +: 8] = 8'h00;
         FLAW_SPACE:   set[8*pos +: 8] = sird_pkg::CHAR_SPACE;
         FLAW_CONTROL: set[8*pos +: 8] = 8'($urandom_range(1, 32));
         FLAW_HIGH:    set[8*pos +: 8] = 8'($urandom_range(128, 255));
         default: begin
            other = $urandom_range(0, n - 2);
            if (other >= pos) other++;
            set[8*pos +: 8] = set[8*other +: 8];
         end
      endcase
      return set;
   endfunction

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic configure(input int n, input logic [127:0] set);
      logic [63:0] len_word;
      len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = 5'(n);
      csr_write(sird_pkg::CSR_BASE_LENGTH, len_word);
      csr_write(sird_pkg::CSR_DIGITS_LOWER, set[63:0]);
      csr_write(sird_pkg::CSR_DIGITS_UPPER, set[127:64]);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_value(input logic signed [31:0] v);
      int gap;
      gap = pick_gap(steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drain before touching the alphabet; dropped values may still be in flight
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // output side: random stalls, occasional long calm runs, long hold on request
   initial begin
      int run;
      int gap;
      forever begin
         if (holds_done != hold_asks) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_bus.ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
         repeat (run) @(posedge clock);
         gap = pick_gap(1'b0);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [127:0] decimal;
      logic [127:0] binary;
      logic [127:0] hex_set;
      logic [127:0] set;
      int           n;
      int           count;
      int           spelled;
      bit           broken;
      decimal = text_alphabet("0123456789");
      binary  = text_alphabet("01");
      hex_set = text_alphabet("!0123456789abcd");
      hex_set[127:120] = 8'h7F;
      spelled = 0;

      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty alphabet after reset
      send_value(32'sd7);

      settle();
      csr_write(CSR_SPARE, {$urandom, $urandom});
      configure(10, decimal);
      send_value(32'sd0);
      send_value(32'sd1);
      send_value(-32'sd1);
      send_value(32'sd10);
      send_value(-32'sd10);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sh8000_0000);
      send_value(32'sd1234567);

      settle();
      configure(2, binary);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sd0);
      send_value(-32'sd1);

      settle();
      configure(16, hex_set);
      send_value(32'sh8000_0000);
      send_value(32'sh7FFF_FFFF);
      send_value(32'sd255);

      // alphabet too short, then too long
      settle();
      configure(1, binary);
      send_value(-32'sd5);
      settle();
      configure(17, hex_set);
      send_value(32'sd100);

      for (int f = FLAW_PLUS; f <= FLAW_REPEAT; f++) begin
         settle();
         configure(10, spoil_alphabet(decimal, 10, flaw_kind_type'(f)));
         send_value(pick_value());
      end

      // long output hold while values keep coming
      settle();
      configure(2, make_alphabet(2));
      steady = 1'b1;
      hold_asks++;
      repeat (40) send_value(pick_value());
      steady = 1'b0;
      spelled += 40;

      while (spelled < SPELLED_TARGET) begin
         n = $urandom_range(2, 16);
         if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 1) ? 2 : 16;
         set = make_alphabet(n);
         broken = 1'b1;
         case ($urandom_range(0, 9))
            0: n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            1: set = spoil_alphabet(set, n, flaw_kind_type'($urandom_range(0, 6)));
            default: broken = 1'b0;
         endcase
         count = broken ? $urandom_range(2, 4) : $urandom_range(15, 40);
         settle();
         configure(n, set);
         steady = ($urandom_range(0, 3) == 0);
         repeat (count) send_value(pick_value());
         steady = 1'b0;
         if (!broken) spelled += count;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
